@@ hw/rtl/swpc_pkg.sv @@
// ----------------------------------------------------------------------------
// swpc_pkg: shared types and constants for the sliding-window peak counter
// Field widths, stream limits and the control bundle for the flag line.
// ----------------------------------------------------------------------------
package swpc_pkg;

  localparam int SAMPLE_W   = 32;       // sample value width
  localparam int WIN_W      = 11;       // window_len register width
  localparam int COUNT_W    = 10;       // peak count width (wraps)
  localparam int POS_W      = 21;       // stream position width
  localparam int OUT_DATA_W = 32;       // result tdata width, byte padded
  localparam int MIN_WINDOW = 3;
  localparam int MAX_WINDOW = 1024;
  localparam int MAX_STREAM = 1048576;

  // Control for the flag line, one bundle shared by every cell
  typedef struct packed {
    logic shift;   // take a new peak flag at the head
    logic rotate;  // rebuild pass: recirculate the history line
    logic flag;    // peak flag of the sample before the current one
  } line_ctl_t;

  // One result item
  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   left_position;
    logic [COUNT_W-1:0] best_parts;
  } result_t;

endpackage

@@ hw/rtl/sliding_window_peak_count.sv @@
// ----------------------------------------------------------------------------
// sliding_window_peak_count: best window by count of inner local peaks
// Counts peaks strictly inside every window of window_len samples and
// reports the highest count plus one and the leftmost 1-based window start
// when the last sample of a stream arrives.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                          Request moves
//  --------  ---------  -------------------------------  ------------------
//  cfg       in         cfg_data: window_len             one register write
//  s_axis    in         tdata: sample, tlast: last       one sample
//  m_axis    out        tdata: best_parts, left_position one stream result
//                       tuser: found
//
//  One sample per cycle unless held off: compare, count update and best
//  tracking finish in the cycle the sample is taken, and the result is
//  registered. A two-slot result buffer keeps samples flowing while a
//  result waits; s_axis holds off once both slots are full. Every write of
//  window_len starts a rebuild pass that reloads the delay row from the
//  history row; s_axis and cfg hold off then. Reset is synchronous; the flag
//  line needs no clearing, only flags of the current stream are ever read.
//
module sliding_window_peak_count #(
  parameter int MAX_WINDOW = swpc_pkg::MAX_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swpc_pkg::WIN_W-1:0]      cfg_data,       // [10:0] window_len

  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swpc_pkg::SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
  input  logic                            s_axis_tlast,   // last_sample

  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] best_parts,
                                                          // [30:10] left_position,
                                                          // [31] zero
  output logic                            m_axis_tuser    // found
);

  localparam int DEPTH = MAX_WINDOW - 2;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int REB_W = $clog2(DEPTH + 1);
  localparam int CW    = swpc_pkg::COUNT_W;
  localparam int PW    = swpc_pkg::POS_W;
  localparam int KW    = swpc_pkg::WIN_W;

  // Configuration: clamped window length and the delay row load point
  logic [KW-1:0]    win_len;
  logic [IDX_W-1:0] inject_idx;
  logic [31:0]      win_clamp;
  logic             cfg_acc;

  // Rebuild sequencer
  logic [REB_W-1:0] reb_cnt;
  logic             rebuilding;

  // Stream state
  logic [swpc_pkg::SAMPLE_W-1:0] prev_sample;
  logic [swpc_pkg::SAMPLE_W-1:0] prev_prev_sample;
  logic [CW-1:0]                 win_count;
  logic [CW-1:0]                 best_count;
  logic [PW-1:0]                 best_start;
  logic [PW-1:0]                 sample_index;
  logic                          have_best;

  // Per-sample datapath
  logic                in_acc;
  logic                active;
  logic                store;
  logic                peak;
  logic                tap;
  logic                full;
  logic                take;
  logic [PW-1:0]       idx_inc;
  logic [PW-1:0]       win_start;
  logic [CW-1:0]       count_add;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       best_count_next;
  logic [PW-1:0]       best_start_next;
  logic                have_best_next;
  swpc_pkg::line_ctl_t line_ctl;
  swpc_pkg::result_t   res_new;

  // Result buffer: output slot plus one skid slot
  logic              out_valid;
  logic              skid_valid;
  swpc_pkg::result_t out_res;
  swpc_pkg::result_t skid_res;
  logic              push;
  logic              out_take;
  logic              main_load;
  logic              skid_load;

  // ---------------------------------------------------------------------------
  // Configuration port; clamp window_len to MIN_WINDOW..MAX_WINDOW on write
  // ---------------------------------------------------------------------------
  assign rebuilding = (reb_cnt != '0);
  assign cfg_ready  = !rebuilding;
  assign cfg_acc    = cfg_valid && cfg_ready;

  always_comb begin
    win_clamp = {{(32-KW){1'b0}}, cfg_data};
    if (win_clamp < 32'(swpc_pkg::MIN_WINDOW)) begin
      win_clamp = 32'(swpc_pkg::MIN_WINDOW);
    end else if (win_clamp > 32'(MAX_WINDOW)) begin
      win_clamp = 32'(MAX_WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len    <= KW'(swpc_pkg::MIN_WINDOW);
      inject_idx <= '0;
    end else if (cfg_acc) begin
      win_len    <= KW'(win_clamp);
      inject_idx <= IDX_W'(win_clamp - 32'(swpc_pkg::MIN_WINDOW));
    end
  end

  // Start a full recirculation of the history row after each write
  always_ff @(posedge clk) begin
    if (rst) begin
      reb_cnt <= '0;
    end else if (cfg_acc) begin
      reb_cnt <= REB_W'(DEPTH);
    end else if (rebuilding) begin
      reb_cnt <= reb_cnt - REB_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Sample path: peak detect, running count, best window
  // ---------------------------------------------------------------------------
  assign s_axis_tready = !rebuilding && !skid_valid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Past the stream limit, drop samples but still honor the last flag
  assign active  = (sample_index < PW'(swpc_pkg::MAX_STREAM));
  assign idx_inc = sample_index + PW'(1);
  assign store   = active && (sample_index != '0);

  // The previous sample is a peak when it beats both neighbors
  assign peak = (sample_index >= PW'(2)) &&
                (prev_sample > prev_prev_sample) &&
                (prev_sample > s_axis_tdata);

  assign line_ctl.shift  = in_acc && store;
  assign line_ctl.rotate = rebuilding;
  assign line_ctl.flag   = peak;

  swpc_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk        (clk),
    .ctl        (line_ctl),
    .inject_idx (inject_idx),
    .tap        (tap)
  );

  always_comb begin
    count_add  = win_count + CW'(store && peak);
    full       = active && (idx_inc >= PW'(win_len));
    // Drop the flag that just left the window's inner span
    count_next = full ? (count_add - CW'(tap)) : count_add;
    win_start  = idx_inc - PW'(win_len) + PW'(1);
    // Strictly greater keeps the leftmost window on ties
    take       = full && (!have_best || (count_next > best_count));

    best_count_next = take ? count_next : best_count;
    best_start_next = take ? win_start  : best_start;
    have_best_next  = take || have_best;

    res_new.found         = have_best_next;
    res_new.best_parts    = have_best_next ? (best_count_next + CW'(1)) : '0;
    res_new.left_position = have_best_next ? best_start_next : '0;
  end

  // Hold the stream state; clear it after the last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      win_count    <= '0;
      best_count   <= '0;
      best_start   <= '0;
      sample_index <= '0;
      have_best    <= 1'b0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        win_count    <= '0;
        best_count   <= '0;
        best_start   <= '0;
        sample_index <= '0;
        have_best    <= 1'b0;
      end else if (active) begin
        win_count    <= count_next;
        best_count   <= best_count_next;
        best_start   <= best_start_next;
        sample_index <= idx_inc;
        have_best    <= have_best_next;
      end
    end
  end

  // Sample history is only read once two samples of the stream are in
  always_ff @(posedge clk) begin
    if (in_acc && active) begin
      prev_prev_sample <= prev_sample;
      prev_sample      <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer
  // ---------------------------------------------------------------------------
  assign push      = in_acc && s_axis_tlast;
  assign out_take  = out_valid && m_axis_tready;
  assign main_load = (out_take || !out_valid) && (skid_valid || push);
  assign skid_load = push && out_valid && !out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take || !out_valid) begin
        out_valid <= skid_valid || push;
      end
      if (main_load) begin
        skid_valid <= 1'b0;
      end else if (skid_load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      out_res <= skid_valid ? skid_res : res_new;
    end
    if (skid_load) begin
      skid_res <= res_new;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.left_position, out_res.best_parts};
  assign m_axis_tuser  = out_res.found;

endmodule

@@ hw/rtl/swpc_cell.sv @@
// ----------------------------------------------------------------------------
// swpc_cell: one cell of the peak flag line
// Holds one history flag (oldest toward the tail) and one delay flag that
// walks toward cell zero; the delay flag is loaded where the window says.
// ----------------------------------------------------------------------------
module swpc_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 1
) (
  input  logic                clk,
  input  swpc_pkg::line_ctl_t ctl,
  input  logic [IDX_W-1:0]    inject_idx,
  input  logic                feed,
  input  logic                hist_in,   // from the younger neighbor
  input  logic                dly_in,    // from the upper neighbor
  output logic                hist_q,
  output logic                dly_q
);

  logic hit;

  assign hit = (inject_idx == IDX_W'(IDX));

  always_ff @(posedge clk) begin
    if (ctl.shift || ctl.rotate) begin
      hist_q <= hist_in;
      dly_q  <= hit ? feed : dly_in;
    end
  end

endmodule

@@ hw/rtl/swpc_chain.sv @@
// ----------------------------------------------------------------------------
// swpc_chain: row of flag cells
// Cell zero of the delay row presents the flag leaving the window; the
// history row recirculates during a rebuild so the delay row can be reloaded.
// ----------------------------------------------------------------------------
module swpc_chain #(
  parameter int DEPTH = swpc_pkg::MAX_WINDOW - 2,
  parameter int IDX_W = 1
) (
  input  logic                clk,
  input  swpc_pkg::line_ctl_t ctl,
  input  logic [IDX_W-1:0]    inject_idx,
  output logic                tap
);

  logic [DEPTH-1:0] hist;
  logic [DEPTH-1:0] dly;
  logic             feed;

  // New flag in normal operation, oldest history flag while rebuilding
  assign feed = ctl.rotate ? hist[DEPTH-1] : ctl.flag;
  assign tap  = dly[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic h_in;
    logic d_in;

    if (i == 0) begin : g_head
      assign h_in = feed;
    end else begin : g_body
      assign h_in = hist[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign d_in = 1'b0;
    end else begin : g_mid
      assign d_in = dly[i+1];
    end

    swpc_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .inject_idx (inject_idx),
      .feed       (feed),
      .hist_in    (h_in),
      .dly_in     (d_in),
      .hist_q     (hist[i]),
      .dly_q      (dly[i])
    );
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sliding-window peak counter
// Streams of samples go in on s_axis, and one result per stream comes back
// on m_axis. A scoreboard class tracks peaks, window counts and the best
// window as each sample is taken, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SAMPLE_W   = swpc_pkg::SAMPLE_W;
  localparam int WIN_W      = swpc_pkg::WIN_W;
  localparam int COUNT_W    = swpc_pkg::COUNT_W;
  localparam int POS_W      = swpc_pkg::POS_W;
  localparam int OUT_DATA_W = swpc_pkg::OUT_DATA_W;
  localparam int MIN_WINDOW = swpc_pkg::MIN_WINDOW;
  localparam int MAX_WINDOW = swpc_pkg::MAX_WINDOW;
  localparam int MAX_STREAM = swpc_pkg::MAX_STREAM;
  localparam int N_ITEMS    = 1700;   // input requests to send in all

  // Tracks the best window of the current stream and holds the results
  // still owed by the block, oldest first.
  class best_window_predictor;
    logic [WIN_W-1:0]    win_len;
    logic [SAMPLE_W-1:0] prev_s;
    logic [SAMPLE_W-1:0] prev2_s;
    bit                  flag_line [MAX_WINDOW];
    logic [COUNT_W-1:0]  inner_peaks;
    logic [COUNT_W-1:0]  best_peaks;
    logic [POS_W-1:0]    best_left;
    logic [POS_W-1:0]    stream_pos;
    bit                  have_best;
    swpc_pkg::result_t   pending_bests [$];
    int                  mismatches;

    function new();
      win_len = WIN_W'(MIN_WINDOW);
      foreach (flag_line[i]) flag_line[i] = 1'b0;
      mismatches = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      prev_s      = '0;
      prev2_s     = '0;
      inner_peaks = '0;
      best_peaks  = '0;
      best_left   = '0;
      stream_pos  = '0;
      have_best   = 1'b0;
    endfunction

    // Window length in use: the register clamped to the legal range
    function int unsigned window_span();
      if (win_len < MIN_WINDOW) return MIN_WINDOW;
      if (win_len > MAX_WINDOW) return MAX_WINDOW;
      return win_len;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      win_len = value;
    endfunction

    // Advance the stream by one accepted sample; on the last one, queue the
    // result and start a fresh stream.
    function void take_sample(logic [SAMPLE_W-1:0] s, logic is_last);
      int unsigned       j;
      int unsigned       k;
      int unsigned       l;
      bit                flag;
      swpc_pkg::result_t r;
      j = stream_pos;
      k = window_span();
      if (j < MAX_STREAM) begin
        if (j >= 1) begin
          // the sample before this one is a peak only with both neighbors
          flag = (j >= 2) && (prev_s > prev2_s) && (prev_s > s);
          flag_line[(j - 1) % MAX_WINDOW] = flag;
          inner_peaks = inner_peaks + COUNT_W'(flag);
        end
        if (j + 1 >= k) begin
          // drop the flag of the window's first sample, which is an end
          l = j + 1 - k;
          inner_peaks = inner_peaks - COUNT_W'(flag_line[l % MAX_WINDOW]);
          if (!have_best || inner_peaks > best_peaks) begin
            best_peaks = inner_peaks;
            best_left  = POS_W'(l + 1);
            have_best  = 1'b1;
          end
        end
        prev2_s    = prev_s;
        prev_s     = s;
        stream_pos = POS_W'(j + 1);
      end
      if (is_last) begin
        r = '0;
        if (have_best) begin
          r.found         = 1'b1;
          r.left_position = best_left;
          r.best_parts    = best_peaks + COUNT_W'(1);
        end
        pending_bests.push_back(r);
        restart_stream();
      end
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] tdata, logic tuser);
      swpc_pkg::result_t  want;
      logic [COUNT_W-1:0] got_parts;
      logic [POS_W-1:0]   got_left;
      got_parts = tdata[COUNT_W-1:0];
      got_left  = tdata[COUNT_W +: POS_W];
      if (pending_bests.size() == 0) begin
        $display("%0t: result with none pending: parts %0d left %0d found %0b",
                 $time, got_parts, got_left, tuser);
        mismatches++;
        return;
      end
      want = pending_bests.pop_front();
      if (got_parts !== want.best_parts) begin
        $display("%0t: best_parts expected %0d, got %0d",
                 $time, want.best_parts, got_parts);
        mismatches++;
      end
      if (got_left !== want.left_position) begin
        $display("%0t: left_position expected %0d, got %0d",
                 $time, want.left_position, got_left);
        mismatches++;
      end
      if (tuser !== want.found) begin
        $display("%0t: found expected %0b, got %0b", $time, want.found, tuser);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [WIN_W-1:0]      cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  best_window_predictor pred = new();

  int tx_idle_pct = 7;          // chance per cycle that the sender idles
  int rx_idle_pct = 7;          // chance per cycle that the receiver stalls
  bit hold_request = 1'b0;      // ask the receiver for a long hold-off
  int hold_left    = 0;
  int samples_sent = 0;

  sliding_window_peak_count dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: stall at random, or hold off for a counted stretch on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = 500;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check every result request at the edge that accepts it
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      pred.match_result(m_axis_tdata, m_axis_tuser);
  end

  // Offer one sample, with random idle cycles ahead of it, and hold it until
  // the block takes it. Valid stays high for a following sample.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tlast  = is_last;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    pred.take_sample(value, is_last);
    samples_sent++;
  endtask

  task automatic send_run(input logic [SAMPLE_W-1:0] values [$]);
    foreach (values[i]) send_sample(values[i], i == values.size() - 1);
  endtask

  // Mostly narrow value ranges, so that ties and plateaus are common
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return SAMPLE_W'($urandom_range(3));
    if (r < 70) return SAMPLE_W'($urandom_range(15));
    if (r < 90) return SAMPLE_W'($urandom);
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic send_random_run(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Drop valid and wait until every result has come back, then let the
  // result buffer go quiet before touching the register.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pred.pending_bests.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    pred.set_window(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [WIN_W-1:0] pick_window();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return WIN_W'($urandom_range(10, MIN_WINDOW));
    if (r < 85) return WIN_W'($urandom_range(40, 11));
    if (r < 92) return WIN_W'($urandom_range(MIN_WINDOW - 1));
    if (r < 96) return WIN_W'($urandom_range(200, 41));
    return WIN_W'($urandom_range(2047, MAX_WINDOW + 1));
  endfunction

  initial begin
    int span;
    int len;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed streams at the reset window length of three
    send_run('{32'h0000_002A});                       // too short for a window
    send_run('{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,   // two equal best windows
               32'hFFFF_FFFF, 32'h0});
    send_run('{32'd7, 32'd7, 32'd7, 32'd3});          // plateau, no peak
    send_run('{32'd1, 32'd2});                        // shorter than window
    send_run('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0});
    drain_results();
    write_window(WIN_W'(4));
    send_run('{32'd0, 32'd9, 32'd0, 32'd9, 32'd0, 32'd9});

    // Register extremes: clamp low, clamp high, widest legal window
    drain_results();
    write_window('0);
    send_random_run(6);
    drain_results();
    write_window('1);
    send_run('{32'd1, 32'd5, 32'd1, 32'd5, 32'd1});
    drain_results();
    write_window(WIN_W'(MAX_WINDOW));
    send_random_run(MAX_WINDOW + 6);

    // Back pressure: hold the receiver off while short streams pile up
    drain_results();
    write_window(WIN_W'(MIN_WINDOW));
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) send_random_run($urandom_range(3, 1));

    // A stretch of streams with no idling on either side
    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 8; i++) send_random_run($urandom_range(30, 5));
    drain_results();
    tx_idle_pct = 7;
    rx_idle_pct = 7;

    // Random streams under random window settings, up to the item budget
    while (samples_sent < N_ITEMS) begin
      drain_results();
      write_window(pick_window());
      span = pred.window_span();
      repeat ($urandom_range(6, 1)) begin
        if (samples_sent < N_ITEMS) begin
          if (span > 200)
            len = $urandom_range(60, 1);
          else if ($urandom_range(99) < 20)
            len = $urandom_range(span, 1);
          else
            len = $urandom_range(span + 30, span);
          if (len > N_ITEMS - samples_sent)
            len = N_ITEMS - samples_sent;
          send_random_run(len);
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (pred.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Stop a hung run
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
